// ----- hdl/ptpd_pkg.sv -----
// Shared types, constants and the tool code table for the pen tablet packet decoder.
`timescale 1ns / 1ps
`default_nettype none

package ptpd_pkg;

  // Default depth of the ASCII reply line counter before it wraps.
  localparam int LINE_BUFFER_BYTES_DEF = 32;

  // A frame is nine bytes; the first eight are held, the ninth arrives live.
  localparam int FRAME_LEN     = 9;
  localparam int FRAME_HELD    = FRAME_LEN - 1;
  localparam int FRAME_AW      = $clog2(FRAME_HELD);

  localparam logic [7:0] BYTE_CR = 8'h0d;

  // First byte classification masks and patterns.
  localparam logic [7:0] MASK_ID       = 8'hfc;
  localparam logic [7:0] PAT_ID        = 8'hc0;
  localparam logic [7:0] MASK_EXIT     = 8'hfe;
  localparam logic [7:0] PAT_EXIT      = 8'h80;
  localparam logic [7:0] MASK_STYLUS   = 8'hb8;
  localparam logic [7:0] PAT_STYLUS    = 8'ha0;
  localparam logic [7:0] MASK_TYPE     = 8'hbe;
  localparam logic [7:0] PAT_AIRBRUSH2 = 8'hb4;
  localparam logic [7:0] PAT_CURSOR_A  = 8'ha8;
  localparam logic [7:0] PAT_CURSOR_B  = 8'hb0;
  localparam logic [7:0] PAT_CURSOR2   = 8'haa;

  // Cursor tool codes (low eleven bits of the stored tool code).
  localparam logic [10:0] CODE_MOUSE_4D = 11'h094;
  localparam logic [10:0] CODE_LENS     = 11'h096;
  localparam logic [10:0] CODE_MOUSE_2D = 11'h007;

  typedef enum logic [2:0] {
    PKT_TOOL_ID  = 3'd0,
    PKT_EXIT     = 3'd1,
    PKT_STYLUS   = 3'd2,
    PKT_CURSOR_1 = 3'd3,
    PKT_CURSOR_2 = 3'd4
  } ptpd_pkt_kind_t;

  typedef enum logic [2:0] {
    TOOL_PEN      = 3'd0,
    TOOL_ERASER   = 3'd1,
    TOOL_BRUSH    = 3'd2,
    TOOL_PENCIL   = 3'd3,
    TOOL_AIRBRUSH = 3'd4,
    TOOL_MOUSE    = 3'd5,
    TOOL_LENS     = 3'd6
  } ptpd_tool_kind_t;

  // Result payload, first field in the highest bits.
  typedef struct packed {
    logic               pad;
    logic [31:0]        serial_number;
    logic signed [1:0]  wheel_step;
    logic [6:0]         button_bits;
    logic [6:0]         tilt_y;
    logic [6:0]         tilt_x;
    logic signed [10:0] z_value;
    logic [15:0]        pos_y;
    logic [15:0]        pos_x;
    logic [2:0]         tool_kind;
    logic               in_proximity;
    logic               channel;
  } ptpd_payload_t;

  typedef struct packed {
    ptpd_pkt_kind_t kind;
    ptpd_payload_t  payload;
  } ptpd_result_t;

  function automatic ptpd_tool_kind_t kind_of_code(input logic [11:0] code);
    ptpd_tool_kind_t k;
    case (code) inside
      12'h812, 12'h012:                         k = TOOL_PENCIL;
      12'h832, 12'h032:                         k = TOOL_BRUSH;
      12'h007, 12'h094, 12'h09c:                k = TOOL_MOUSE;
      12'h096:                                  k = TOOL_LENS;
      12'h82a, 12'h85a, 12'h91a, 12'hd1a, 12'h0fa: k = TOOL_ERASER;
      12'hd12, 12'h912, 12'h112:                k = TOOL_AIRBRUSH;
      default:                                  k = TOOL_PEN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/pen_tablet_packet_decoder.sv -----
// Top level of the pen tablet packet decoder: framing, decode, channel state, output skid.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Contents
// in_      slave      one serial byte per transfer (in_tdata[7:0])
// out_     master     one decoded frame per transfer, packet kind on out_tuser
//
// Bytes are taken while in_tready is high. The ninth byte of a frame is decoded in the
// same cycle it is accepted. The result lands in the output register on that edge, or in
// the skid register when the output register still holds a result that is not leaving.
// The channel state is written on the same edge, so a following frame sees it at once.
// A two-entry output stage (output register plus skid register) keeps in_tready high
// while one result waits; in_tready drops only when both entries are full.
// rst_n is synchronous and active low; it clears the counter, channel state and valids.
// Frame byte registers are not reset: they are always written before they are read.
module pen_tablet_packet_decoder import ptpd_pkg::*; #(
  parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // [7:0] rx_byte
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // [0] channel, [1] in_proximity, [4:2] tool_kind, [20:5] pos_x, [36:21] pos_y,
  // [47:37] z_value, [54:48] tilt_x, [61:55] tilt_y, [68:62] button_bits,
  // [70:69] wheel_step, [102:71] serial_number, [103] zero
  output logic [103:0]       out_tdata,
  output logic [2:0]         out_tuser   // [2:0] packet_kind
);

  // The byte counter must hold the line limit itself.
  localparam int IW = $clog2(LINE_BUFFER_BYTES + 1);

  // Framing state.
  logic [IW-1:0] idx_r, idx_nxt;
  logic          fbh_r, fbh_nxt;
  logic [7:0]    frame_r [FRAME_HELD];

  // Per-channel tool state.
  logic [11:0]     code_r   [2];
  ptpd_tool_kind_t tkind_r  [2];
  logic [31:0]     serial_r [2];
  logic [1:0]      prox_r;

  // Output stage.
  logic         out_valid_r, skid_valid_r;
  ptpd_result_t out_data_r, skid_data_r;

  logic          in_fire, out_fire;
  logic [IW-1:0] idx_eff, idx_inc;
  logic          fbh_eff;
  logic          decode_now;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_valid_r && out_tready;
  assign in_tready = !skid_valid_r;

  // A top-bit byte restarts the count; an overlong line wraps to zero.
  always_comb begin
    if (in_tdata[7] || idx_r >= IW'(LINE_BUFFER_BYTES)) begin
      idx_eff = '0;
    end else begin
      idx_eff = idx_r;
    end
    idx_inc    = idx_eff + IW'(1);
    fbh_eff    = (idx_eff == '0) ? in_tdata[7] : fbh_r;
    decode_now = (idx_inc == IW'(FRAME_LEN)) && fbh_eff;
    if (decode_now) begin
      idx_nxt = '0;
    end else if (in_tdata == BYTE_CR && !fbh_eff) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = idx_inc;
    end
    fbh_nxt = fbh_eff;
  end

  // Frame decode. Bytes 0..7 come from the frame registers, byte 8 is the live byte.
  logic [7:0]      d0, d1, d2, d3, d4, d5, d6, d7, d8;
  logic            ch;
  logic            is_id, is_exit, is_pen_any, is_pen_main, is_cur1, is_cur2, type_ok;
  logic            known;
  logic            res_valid;
  logic [11:0]     new_code;
  logic [31:0]     new_serial;
  ptpd_tool_kind_t new_tkind;
  logic            new_prox;
  logic            values;
  logic [9:0]      mag;
  logic [10:0]     code11;
  ptpd_result_t    res;

  always_comb begin
    d0 = frame_r[0];
    d1 = frame_r[1];
    d2 = frame_r[2];
    d3 = frame_r[3];
    d4 = frame_r[4];
    d5 = frame_r[5];
    d6 = frame_r[6];
    d7 = frame_r[7];
    d8 = in_tdata;
    ch = d0[0];

    is_id       = (d0 & MASK_ID) == PAT_ID;
    is_exit     = (d0 & MASK_EXIT) == PAT_EXIT;
    is_pen_main = (d0 & MASK_STYLUS) == PAT_STYLUS;
    is_pen_any  = is_pen_main || ((d0 & MASK_TYPE) == PAT_AIRBRUSH2);
    is_cur1     = ((d0 & MASK_TYPE) == PAT_CURSOR_A) || ((d0 & MASK_TYPE) == PAT_CURSOR_B);
    is_cur2     = (d0 & MASK_TYPE) == PAT_CURSOR2;
    type_ok     = is_pen_any || is_cur1 || is_cur2;
    known       = code_r[ch] != '0;

    // A tool id frame always reports; anything else needs a known tool and a known type.
    res_valid = decode_now && (is_id || (known && (is_exit || type_ok)));

    new_code   = {d1[6:0], d2[6:2]};
    new_serial = {d2[1:0], d3[6:0], d4[6:0], d5[6:0], d6[6:0], d7[6:5]};
    new_tkind  = kind_of_code(new_code);
    new_prox   = !is_id && !is_exit && d0[6];
    values     = new_prox;

    mag    = {d5[2:0], d6[6:0]};
    code11 = code_r[ch][10:0];

    res = '0;
    if (is_id) begin
      res.kind = PKT_TOOL_ID;
    end else if (is_exit) begin
      res.kind = PKT_EXIT;
    end else if (is_pen_any) begin
      res.kind = PKT_STYLUS;
    end else if (is_cur1) begin
      res.kind = PKT_CURSOR_1;
    end else begin
      res.kind = PKT_CURSOR_2;
    end
    res.payload.channel       = ch;
    res.payload.in_proximity  = new_prox;
    res.payload.tool_kind     = is_id ? new_tkind : tkind_r[ch];
    res.payload.serial_number = is_id ? new_serial : serial_r[ch];

    if (values) begin
      res.payload.pos_x = {d1[6:0], d2[6:0], d3[6:5]};
      res.payload.pos_y = {d3[4:0], d4[6:0], d5[6:3]};
      if (is_pen_any) begin
        // Only the first stylus frame carries pressure and side buttons.
        if (is_pen_main) begin
          res.payload.z_value     = {1'b0, mag};
          res.payload.button_bits = {4'b0, d0[2:1], 1'b0};
        end
        res.payload.tilt_x = {~d7[6], d7[5:0]};
        res.payload.tilt_y = {~d8[6], d8[5:0]};
      end else if (is_cur1) begin
        case (code11)
          CODE_MOUSE_4D: begin
            res.payload.z_value = d8[3] ? -{1'b0, mag} : {1'b0, mag};
          end
          CODE_LENS: begin
            res.payload.button_bits = d8[6:0];
          end
          CODE_MOUSE_2D: begin
            res.payload.button_bits = {4'b0, d8[4:2]};
            res.payload.wheel_step  = {1'b0, d8[1]} - {1'b0, d8[0]};
          end
          default: begin
            // Other cursor tools report position only.
          end
        endcase
      end
    end
  end

  // Framing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      fbh_r <= 1'b0;
    end else if (in_fire) begin
      idx_r <= idx_nxt;
      fbh_r <= fbh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && idx_eff < IW'(FRAME_HELD)) begin
      frame_r[idx_eff[FRAME_AW-1:0]] <= in_tdata;
    end
  end

  // Channel state is updated only by frames that produce a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r   <= '{default: '0};
      tkind_r  <= '{default: TOOL_PEN};
      serial_r <= '{default: '0};
      prox_r   <= '0;
    end else if (in_fire && res_valid) begin
      prox_r[ch] <= new_prox;
      if (is_id) begin
        code_r[ch]   <= new_code;
        tkind_r[ch]  <= new_tkind;
        serial_r[ch] <= new_serial;
      end
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r.payload;
  assign out_tuser  = out_data_r.kind;

  // The skid entry is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without a result in the output register");

  // The line counter never passes its limit.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IW'(LINE_BUFFER_BYTES))
    else $error("byte counter beyond the line limit");

  // After a decoded frame is accepted, the output register holds a valid result on the next cycle.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_valid) |=> out_valid_r)
    else $error("decoded frame lost");

  // Tool id and exit results always report the channel out of proximity.
  a_id_out_of_prox: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.kind == PKT_TOOL_ID || out_data_r.kind == PKT_EXIT))
      |-> !out_data_r.payload.in_proximity)
    else $error("tool id or exit result reports proximity");

  // Out of proximity results carry no position.
  a_zero_when_away: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.payload.in_proximity)
      |-> (out_data_r.payload.pos_x == '0 && out_data_r.payload.pos_y == '0))
    else $error("position reported while out of proximity");

endmodule

`default_nettype wire

// ----- sim/pen_tablet_packet_decoder_tb.sv -----
// Testbench for the pen tablet packet decoder: byte stream stimulus, decode prediction, checks.
`timescale 1ns / 1ps

module pen_tablet_packet_decoder_tb import ptpd_pkg::*; ();

  // Line counter depth used by both the block and the predictor.
  localparam int LINE_MAX = 32;
  localparam int FRAME_BYTES = 9;

  // First byte patterns, written out here so the prediction does not lean on the package.
  localparam logic [7:0] HEAD_ID_MASK   = 8'hfc;
  localparam logic [7:0] HEAD_ID        = 8'hc0;
  localparam logic [7:0] HEAD_EXIT_MASK = 8'hfe;
  localparam logic [7:0] HEAD_EXIT      = 8'h80;
  localparam logic [7:0] HEAD_PEN_MASK  = 8'hb8;
  localparam logic [7:0] HEAD_STYLUS    = 8'ha0;
  localparam logic [7:0] HEAD_TYPE_MASK = 8'hbe;
  localparam logic [7:0] HEAD_AIRBRUSH2 = 8'hb4;
  localparam logic [7:0] HEAD_CURSOR_A  = 8'ha8;
  localparam logic [7:0] HEAD_CURSOR_B  = 8'hb0;
  localparam logic [7:0] HEAD_CURSOR2   = 8'haa;
  localparam logic [7:0] CHAR_CR        = 8'h0d;

  // Cursor tools that report more than position (low eleven bits of the tool code).
  localparam logic [10:0] CUR_MOUSE_4D = 11'h094;
  localparam logic [10:0] CUR_LENS     = 11'h096;
  localparam logic [10:0] CUR_MOUSE_2D = 11'h007;

  // Tool codes that the random part picks from; the cursor codes appear often on purpose.
  localparam logic [11:0] TOOL_CODES [24] = '{
    12'h812, 12'h012, 12'h832, 12'h032, 12'h007, 12'h094, 12'h09c, 12'h096,
    12'h82a, 12'h85a, 12'h91a, 12'hd1a, 12'h0fa, 12'hd12, 12'h912, 12'h112,
    12'h894, 12'h896, 12'h807, 12'h094, 12'h096, 12'h007, 12'h022, 12'h555
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;    // [7:0] rx_byte
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;        // channel .. serial_number, see ptpd_payload_t
  logic [2:0]   out_tuser;        // [2:0] packet_kind

  pen_tablet_packet_decoder #(
    .LINE_BUFFER_BYTES(LINE_MAX)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be sent, and decoded packets waiting to come out.
  logic [7:0]   byte_feed [$];
  ptpd_result_t expected_pkts [$];
  int           bytes_queued = 0;
  int           fail_count = 0;
  int           pkts_seen = 0;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int           send_idle_pct = 0;
  int           sink_stall_pct = 0;

  // Decoder state as the predictor sees it.
  logic [7:0]      frame_buf [FRAME_BYTES];
  int              fill_count = 0;
  bit              frame_started = 1'b0;
  logic [11:0]     ch_code [2];
  ptpd_tool_kind_t ch_kind [2];
  logic [31:0]     ch_serial [2];
  bit              ch_prox [2];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns, packet %0d: %s", $time, pkts_seen, msg);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", what, got, want));
    end
  endtask

  function automatic ptpd_tool_kind_t tool_class(input logic [11:0] code);
    case (code)
      12'h812, 12'h012:                            return TOOL_PENCIL;
      12'h832, 12'h032:                            return TOOL_BRUSH;
      12'h007, 12'h094, 12'h09c:                   return TOOL_MOUSE;
      12'h096:                                     return TOOL_LENS;
      12'h82a, 12'h85a, 12'h91a, 12'hd1a, 12'h0fa: return TOOL_ERASER;
      12'hd12, 12'h912, 12'h112:                   return TOOL_AIRBRUSH;
      default:                                     return TOOL_PEN;
    endcase
  endfunction

  // Decodes the nine held bytes. Returns 0 when the frame gives no packet.
  function automatic bit decode_held_frame(output ptpd_result_t pkt);
    logic [7:0]     b0;
    bit             ch;
    bit             with_values;
    logic [11:0]    code;
    logic [10:0]    low_code;
    logic [9:0]     mag;
    int             w;
    ptpd_pkt_kind_t k;
    pkt = '0;
    b0 = frame_buf[0];
    ch = b0[0];
    with_values = 1'b0;
    if ((b0 & HEAD_ID_MASK) == HEAD_ID) begin
      // Tool identification: take the new tool and serial, the tool is not yet near.
      code = {frame_buf[1][6:0], frame_buf[2][6:2]};
      ch_prox[ch] = 1'b0;
      ch_serial[ch] = {frame_buf[2][1:0], frame_buf[3][6:0], frame_buf[4][6:0],
                       frame_buf[5][6:0], frame_buf[6][6:0], frame_buf[7][6:5]};
      ch_code[ch] = code;
      ch_kind[ch] = tool_class(code);
      k = PKT_TOOL_ID;
    end else if (ch_code[ch] == '0) begin
      return 1'b0;
    end else if ((b0 & HEAD_EXIT_MASK) == HEAD_EXIT) begin
      ch_prox[ch] = 1'b0;
      k = PKT_EXIT;
    end else begin
      if ((b0 & HEAD_PEN_MASK) == HEAD_STYLUS || (b0 & HEAD_TYPE_MASK) == HEAD_AIRBRUSH2) begin
        k = PKT_STYLUS;
      end else if ((b0 & HEAD_TYPE_MASK) == HEAD_CURSOR_A ||
                   (b0 & HEAD_TYPE_MASK) == HEAD_CURSOR_B) begin
        k = PKT_CURSOR_1;
      end else if ((b0 & HEAD_TYPE_MASK) == HEAD_CURSOR2) begin
        k = PKT_CURSOR_2;
      end else begin
        return 1'b0;
      end
      ch_prox[ch] = b0[6];
      with_values = b0[6];
    end

    if (with_values) begin
      low_code = ch_code[ch][10:0];
      mag = {frame_buf[5][2:0], frame_buf[6][6:0]};
      pkt.payload.pos_x = {frame_buf[1][6:0], frame_buf[2][6:0], frame_buf[3][6:5]};
      pkt.payload.pos_y = {frame_buf[3][4:0], frame_buf[4][6:0], frame_buf[5][6:3]};
      if (k == PKT_STYLUS) begin
        // Only the regular stylus frame carries pressure and side buttons.
        if ((b0 & HEAD_PEN_MASK) == HEAD_STYLUS) begin
          pkt.payload.z_value = {1'b0, mag};
          pkt.payload.button_bits = {4'b0, b0[2:1], 1'b0};
        end
        pkt.payload.tilt_x = {~frame_buf[7][6], frame_buf[7][5:0]};
        pkt.payload.tilt_y = {~frame_buf[8][6], frame_buf[8][5:0]};
      end else if (k == PKT_CURSOR_1) begin
        if (low_code == CUR_MOUSE_4D) begin
          pkt.payload.z_value = frame_buf[8][3] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end else if (low_code == CUR_LENS) begin
          pkt.payload.button_bits = frame_buf[8][6:0];
        end else if (low_code == CUR_MOUSE_2D) begin
          pkt.payload.button_bits = {4'b0, frame_buf[8][4:2]};
          w = int'(frame_buf[8][1]) - int'(frame_buf[8][0]);
          pkt.payload.wheel_step = w[1:0];
        end
      end
    end

    pkt.kind = k;
    pkt.payload.channel = ch;
    pkt.payload.in_proximity = ch_prox[ch];
    pkt.payload.tool_kind = ch_kind[ch];
    pkt.payload.serial_number = ch_serial[ch];
    return 1'b1;
  endfunction

  // Framing: a byte with the top bit starts a frame, a line ends at carriage return
  // or wraps when it grows too long.
  task automatic absorb_byte(input logic [7:0] b);
    ptpd_result_t pkt;
    if (b[7]) fill_count = 0;
    if (fill_count >= LINE_MAX) fill_count = 0;
    if (fill_count == 0) frame_started = b[7];
    if (fill_count < FRAME_BYTES) frame_buf[fill_count] = b;
    fill_count++;
    if (fill_count == FRAME_BYTES && frame_started) begin
      if (decode_held_frame(pkt)) expected_pkts.push_back(pkt);
      fill_count = 0;
    end else if (b == CHAR_CR && !frame_started) begin
      fill_count = 0;
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    byte_feed.push_back(b);
    bytes_queued++;
  endtask

  // A well-formed frame: body byte i is body[8*i +: 8] with its top bit cleared.
  task automatic push_frame(input logic [7:0] head, input logic [63:0] body);
    push_byte(head);
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      push_byte({1'b0, body[8*i +: 7]});
    end
  endtask

  task automatic push_tool_id(input bit ch, input logic [11:0] code, input logic [31:0] sn);
    logic [63:0] body;
    body = {$urandom, $urandom};
    body[6:0]   = code[11:5];
    body[14:8]  = {code[4:0], sn[31:30]};
    body[22:16] = sn[29:23];
    body[30:24] = sn[22:16];
    body[38:32] = sn[15:9];
    body[46:40] = sn[8:2];
    body[54:53] = sn[1:0];
    push_frame(HEAD_ID | {6'b0, 1'($urandom_range(1)), ch}, body);
  endtask

  task automatic push_line(input int len);
    for (int i = 0; i < len; i++) push_byte(8'($urandom_range(127)));
    push_byte(CHAR_CR);
  endtask

  // A line that never ends, so the counter has to wrap.
  task automatic push_overlong_line(input int len);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      c = 8'($urandom_range(127));
      if (c == CHAR_CR) c = c + 8'd1;
      push_byte(c);
    end
  endtask

  function automatic logic [11:0] pick_code();
    if ($urandom_range(99) < 3) return '0;
    if ($urandom_range(99) < 4) return 12'($urandom);
    return TOOL_CODES[$urandom_range(23)];
  endfunction

  function automatic logic [7:0] random_head();
    logic [7:0] h;
    int         r;
    r = $urandom_range(99);
    if (r < 8) begin
      h = HEAD_EXIT | 8'($urandom_range(1));
    end else if (r < 40) begin
      h = HEAD_STYLUS | 8'($urandom_range(7));
    end else if (r < 50) begin
      h = HEAD_AIRBRUSH2 | 8'($urandom_range(1));
    end else if (r < 75) begin
      h = ($urandom_range(1) ? HEAD_CURSOR_A : HEAD_CURSOR_B) | 8'($urandom_range(1));
    end else if (r < 90) begin
      h = HEAD_CURSOR2 | 8'($urandom_range(1));
    end else begin
      h = {1'b1, 7'($urandom_range(127))};
    end
    // Most pointer frames have the tool near the surface.
    if (r >= 8 && r < 90) h[6] = ($urandom_range(99) < 85);
    return h;
  endfunction

  // Mostly well-formed frames with random content, then lines, broken frames and noise.
  task automatic push_random(input int n);
    int stop;
    int r;
    stop = bytes_queued + n;
    while (bytes_queued < stop) begin
      r = $urandom_range(99);
      if (r < 12) begin
        push_tool_id(1'($urandom_range(1)), pick_code(), $urandom);
      end else if (r < 82) begin
        push_frame(random_head(), {$urandom, $urandom});
      end else if (r < 88) begin
        push_line($urandom_range(0, 15));
      end else if (r < 91) begin
        push_overlong_line($urandom_range(LINE_MAX + 1, 2 * LINE_MAX + 6));
      end else if (r < 96) begin
        push_byte(random_head());
        repeat ($urandom_range(1, 7)) push_byte(8'($urandom_range(127)));
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end
    end
  endtask

  task automatic push_directed();
    // Nothing is known about either tool yet, so these give no packet.
    push_frame(HEAD_STYLUS | 8'h47, {8{8'h7f}});
    push_frame(HEAD_EXIT | 8'h01, '0);
    // Pencil on channel 0, extremes of the stylus fields.
    push_tool_id(1'b0, 12'h812, 32'hffff_ffff);
    push_frame(HEAD_STYLUS | 8'h47, {8{8'h7f}});
    push_frame(HEAD_STYLUS | 8'h40, '0);
    push_frame(HEAD_STYLUS | 8'h06, {8{8'h7f}});
    push_frame(HEAD_AIRBRUSH2 | 8'h40, {$urandom, $urandom});
    // 4D mouse on channel 1: throttle of both signs, then a second cursor frame.
    push_tool_id(1'b1, 12'h094, 32'h0);
    push_frame(HEAD_CURSOR_A | 8'h41, 64'h0f7f_7f7f_7f7f_7f7f);
    push_frame(HEAD_CURSOR_B | 8'h41, 64'h007f_7f7f_7f7f_7f7f);
    push_frame(HEAD_CURSOR2 | 8'h41, {$urandom, $urandom});
    // Lens buttons, then 2D mouse wheel up, down and both.
    push_tool_id(1'b1, 12'h096, $urandom);
    push_frame(HEAD_CURSOR_A | 8'h41, {8'h7f, 56'($urandom)});
    push_tool_id(1'b1, 12'h007, $urandom);
    push_frame(HEAD_CURSOR_A | 8'h41, {8'h02, 56'($urandom)});
    push_frame(HEAD_CURSOR_B | 8'h41, {8'h1d, 56'($urandom)});
    push_frame(HEAD_CURSOR_A | 8'h41, {8'h03, 56'($urandom)});
    // Airbrush with a cursor frame gives position only; unknown and exit frames.
    push_tool_id(1'b0, 12'hd12, $urandom);
    push_frame(HEAD_CURSOR_A | 8'h40, {8'h7f, 56'($urandom)});
    push_frame(8'h88, {$urandom, $urandom});
    push_frame(HEAD_EXIT, {$urandom, $urandom});
    // A reply line, a line that wraps, and carriage returns inside a frame.
    push_byte(8'h7e); push_byte(8'h23); push_byte(8'h41); push_byte(CHAR_CR);
    push_overlong_line(LINE_MAX + 8);
    push_frame(HEAD_STYLUS | 8'h41, {8{CHAR_CR}});
    // A frame cut short by the next one, unknown code, then a cleared tool.
    push_byte(HEAD_STYLUS | 8'h40); push_byte(8'h11); push_byte(8'h22);
    push_tool_id(1'b0, 12'h555, $urandom);
    push_frame(HEAD_STYLUS | 8'h40, {$urandom, $urandom});
    push_tool_id(1'b0, 12'h000, $urandom);
    push_frame(HEAD_STYLUS | 8'h40, {$urandom, $urandom});
  endtask

  task automatic wait_drained();
    while (byte_feed.size() != 0 || expected_pkts.size() != 0) @(posedge clk);
  endtask

  // Sender: holds a byte until it is taken, otherwise offers the next one or idles.
  always @(posedge clk) begin : byte_sender
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        absorb_byte(in_tdata);
        void'(byte_feed.pop_front());
      end
      if (!(in_tvalid && !in_tready)) begin
        if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= byte_feed[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, and every transfer is checked against the oldest packet.
  always @(posedge clk) begin : pkt_checker
    ptpd_payload_t got;
    ptpd_result_t  want;
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_pkts.size() == 0) begin
        report_mismatch("packet arrived with none expected");
      end else begin
        want = expected_pkts.pop_front();
        check_field("packet_kind", 32'(out_tuser), 32'(want.kind));
        check_field("channel", 32'(got.channel), 32'(want.payload.channel));
        check_field("in_proximity", 32'(got.in_proximity), 32'(want.payload.in_proximity));
        check_field("tool_kind", 32'(got.tool_kind), 32'(want.payload.tool_kind));
        check_field("pos_x", 32'(got.pos_x), 32'(want.payload.pos_x));
        check_field("pos_y", 32'(got.pos_y), 32'(want.payload.pos_y));
        check_field("z_value", 32'(unsigned'(got.z_value)), 32'(unsigned'(want.payload.z_value)));
        check_field("tilt_x", 32'(got.tilt_x), 32'(want.payload.tilt_x));
        check_field("tilt_y", 32'(got.tilt_y), 32'(want.payload.tilt_y));
        check_field("button_bits", 32'(got.button_bits), 32'(want.payload.button_bits));
        check_field("wheel_step", 32'(unsigned'(got.wheel_step)),
                    32'(unsigned'(want.payload.wheel_step)));
        check_field("serial_number", got.serial_number, want.payload.serial_number);
        check_field("pad", 32'(got.pad), 32'(1'b0));
      end
      pkts_seen++;
    end
  end

  initial begin : run_phases
    for (int i = 0; i < 2; i++) begin
      ch_code[i] = '0;
      ch_kind[i] = TOOL_PEN;
      ch_serial[i] = '0;
      ch_prox[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Free-running, then sender gaps, then receiver stalls, then both.
    push_directed();
    push_random(230);
    wait_drained();
    send_idle_pct = 72;
    push_random(230);
    wait_drained();
    send_idle_pct = 0;
    sink_stall_pct = 72;
    push_random(230);
    wait_drained();
    send_idle_pct = 22;
    sink_stall_pct = 22;
    push_random(230);
    wait_drained();

    // Extra cycles after the drain catch any stray packet.
    repeat (20) @(posedge clk);
    if (expected_pkts.size() != 0) begin
      report_mismatch($sformatf("%0d packets never arrived", expected_pkts.size()));
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    report_mismatch($sformatf("timed out with %0d bytes unsent and %0d packets outstanding",
                              byte_feed.size(), expected_pkts.size()));
    $display("Test completed with failures");
    $finish;
  end

endmodule
